>>> design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants and types of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Default word width and number of fraction bits (Q16.16)
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Operation codes of the shared add/subtract unit
    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Configuration register indexes
    typedef enum logic
    {
        REG_PROCESS_NOISE,
        REG_MEASURE_NOISE
    } reg_idx_t;

endpackage

>>> design/skf_cfg.sv
// ----------------------------------------------------------------------------
// skf_cfg
// APB register file holding the process and measurement noise variances.
// ----------------------------------------------------------------------------
module skf_cfg
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int BUS_WIDTH  = 32,
    parameter int ADDR_WIDTH = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [BUS_WIDTH-1:0]  pwdata,
    output logic [BUS_WIDTH-1:0]  prdata,
    output logic [DATA_WIDTH-1:0] process_noise,
    output logic [DATA_WIDTH-1:0] measure_noise
);

    localparam logic [DATA_WIDTH-1:0] NOISE_RESET = DATA_WIDTH'(1) << FRAC_BITS;

    logic [DATA_WIDTH-1:0] process_noise_reg;
    logic [DATA_WIDTH-1:0] measure_noise_reg;
    reg_idx_t              reg_idx;
    logic                  wr_en;

    assign reg_idx = reg_idx_t'(paddr[ADDR_WIDTH-1]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_noise_reg <= NOISE_RESET;
            measure_noise_reg <= NOISE_RESET;
        end
        else if (wr_en)
        begin
            // Bits above the word width are dropped
            case (reg_idx)
                REG_PROCESS_NOISE: process_noise_reg <= pwdata[DATA_WIDTH-1:0];
                REG_MEASURE_NOISE: measure_noise_reg <= pwdata[DATA_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PROCESS_NOISE: prdata = BUS_WIDTH'(process_noise_reg);
            REG_MEASURE_NOISE: prdata = BUS_WIDTH'(measure_noise_reg);
            default:           prdata = '0;
        endcase
    end

    assign process_noise = process_noise_reg;
    assign measure_noise = measure_noise_reg;

endmodule

>>> design/skf_alu.sv
// ----------------------------------------------------------------------------
// skf_alu
// Shared add/subtract unit; carry is the carry out on add, the borrow on sub.
// ----------------------------------------------------------------------------
module skf_alu
    import skf_pkg::*;
#(
    parameter int WIDTH = 50
)
(
    input  alu_op_t          op,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] result,
    output logic             carry
);

    logic [WIDTH:0] ext;

    always_comb
    begin
        case (op)
            ALU_ADD: ext = {1'b0, a} + {1'b0, b};
            ALU_SUB: ext = {1'b0, a} - {1'b0, b};
            default: ext = '0;
        endcase
    end

    assign result = ext[WIDTH-1:0];
    assign carry  = ext[WIDTH];

endmodule

>>> design/skf_core.sv
// ----------------------------------------------------------------------------
// skf_core
// Sequencer and datapath registers; all arithmetic runs through one skf_alu.
// ----------------------------------------------------------------------------
module skf_core
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DATA_WIDTH-1:0] process_noise,
    input  logic [DATA_WIDTH-1:0] measure_noise,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] measurement,
    input  logic                  slot_free,
    output logic                  res_valid,
    output logic [DATA_WIDTH-1:0] estimate
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int AW = W + F + 2;
    localparam int CW = $clog2(F + 1);
    localparam logic [CW-1:0] CNT_START = CW'(F);
    localparam logic [AW-1:0] ONE_FX    = AW'(1) << F;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_PRED,
        S_DEN,
        S_INN,
        S_NEG,
        S_DIV,
        S_MUL1,
        S_UPD,
        S_ONEM,
        S_MUL2,
        S_FIN
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic [W-1:0]    est_reg;
    logic [W-1:0]    cov_reg;

    logic [W-1:0]    z_reg;
    logic [W-1:0]    pm_reg;
    logic [W:0]      den_reg;
    logic [W:0]      inn_reg;
    logic            neg_reg;
    logic [W:0]      mcand_reg;
    logic [W:0]      rem_reg;
    logic [F:0]      q_reg;
    logic [F:0]      mlt_reg;
    logic [AW-1:0]   acc_reg;

    alu_op_t         alu_op;
    logic [AW-1:0]   alu_a;
    logic [AW-1:0]   alu_b;
    logic [AW-1:0]   alu_res;
    logic            alu_carry;

    logic            accept;
    logic            last_step;
    logic            den_zero;
    logic [W+1:0]    trial;
    logic [F:0]      q_new;
    logic [W:0]      corr;
    logic            sat_hi;
    logic            sat_lo;
    logic [W-1:0]    est_sat;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign last_step = (cnt_reg == '0);
    assign den_zero  = (den_reg == '0);
    // The first division step compares the numerator without a shift
    assign trial     = (cnt_reg == CNT_START) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign q_new     = {q_reg[F-1:0], ~alu_carry};
    assign corr      = acc_reg[W+F:F];

    // Clamp the corrected estimate to the signed word range
    assign sat_hi  = !alu_res[AW-1] && (|alu_res[AW-2:W-1]);
    assign sat_lo  = alu_res[AW-1] && !(&alu_res[AW-2:W-1]);
    assign est_sat = sat_hi ? {1'b0, {(W-1){1'b1}}} :
                     sat_lo ? {1'b1, {(W-1){1'b0}}} : alu_res[W-1:0];

    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_PRED:
            begin
                alu_a = AW'(cov_reg);
                alu_b = AW'(process_noise);
            end
            S_DEN:
            begin
                alu_a = AW'(pm_reg);
                alu_b = AW'(measure_noise);
            end
            S_INN:
            begin
                alu_op = ALU_SUB;
                alu_a  = {{(AW-W){z_reg[W-1]}}, z_reg};
                alu_b  = {{(AW-W){est_reg[W-1]}}, est_reg};
            end
            S_NEG:
            begin
                alu_op = ALU_SUB;
                alu_b  = {{(AW-W-1){inn_reg[W]}}, inn_reg};
            end
            S_DIV:
            begin
                alu_op = ALU_SUB;
                alu_a  = AW'(trial);
                alu_b  = AW'(den_reg);
            end
            S_MUL1, S_MUL2:
            begin
                alu_a = {acc_reg[AW-2:0], 1'b0};
                alu_b = mlt_reg[F] ? AW'(mcand_reg) : '0;
            end
            S_UPD:
            begin
                alu_op = neg_reg ? ALU_SUB : ALU_ADD;
                alu_a  = {{(AW-W){est_reg[W-1]}}, est_reg};
                alu_b  = AW'(corr);
            end
            S_ONEM:
            begin
                alu_op = ALU_SUB;
                alu_a  = ONE_FX;
                alu_b  = AW'(q_reg);
            end
            default: ;
        endcase
    end

    skf_alu #(
        .WIDTH (AW)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .carry  (alu_carry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            est_reg   <= '0;
            cov_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_PRED;
                    end
                end
                S_PRED: state_reg <= S_DEN;
                S_DEN:  state_reg <= S_INN;
                S_INN:  state_reg <= S_NEG;
                S_NEG:
                begin
                    cnt_reg   <= CNT_START;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (last_step)
                    begin
                        cnt_reg   <= CNT_START;
                        state_reg <= S_MUL1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                S_MUL1:
                begin
                    if (last_step)
                    begin
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                S_UPD:
                begin
                    est_reg   <= est_sat;
                    state_reg <= S_ONEM;
                end
                S_ONEM:
                begin
                    cnt_reg   <= CNT_START;
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    if (last_step)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                S_FIN:
                begin
                    cov_reg <= acc_reg[W+F-1:F];
                    // Hold until the output register can take the result
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    z_reg <= measurement;
                end
            end
            S_PRED:
            begin
                pm_reg <= alu_res[W] ? '1 : alu_res[W-1:0];
            end
            S_DEN:
            begin
                den_reg <= alu_res[W:0];
                rem_reg <= {1'b0, pm_reg};
                q_reg   <= '0;
            end
            S_INN:
            begin
                inn_reg <= alu_res[W:0];
            end
            S_NEG:
            begin
                neg_reg   <= inn_reg[W];
                mcand_reg <= inn_reg[W] ? alu_res[W:0] : inn_reg;
            end
            S_DIV:
            begin
                rem_reg <= alu_carry ? trial[W:0] : alu_res[W:0];
                if (last_step)
                begin
                    // A zero denominator forces the gain to zero
                    q_reg   <= den_zero ? '0 : q_new;
                    mlt_reg <= den_zero ? '0 : q_new;
                    acc_reg <= '0;
                end
                else
                begin
                    q_reg <= q_new;
                end
            end
            S_MUL1, S_MUL2:
            begin
                acc_reg <= alu_res;
                mlt_reg <= {mlt_reg[F-1:0], 1'b0};
            end
            S_ONEM:
            begin
                mlt_reg   <= alu_res[F:0];
                mcand_reg <= {1'b0, pm_reg};
                acc_reg   <= '0;
            end
            default: ;
        endcase
    end

    assign res_valid = (state_reg == S_FIN) && slot_free;
    assign estimate  = est_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_pred_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEN) |-> (pm_reg >= cov_reg))
        else $error("predicted covariance wrapped");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL1) |-> (q_reg <= ONE_FX[F:0]))
        else $error("gain above one");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL1 && !den_zero) |-> (rem_reg < den_reg))
        else $error("division remainder not reduced");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (state_reg == S_IDLE) && !res_valid)
        else $error("result issued twice");

endmodule

>>> design/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// First-order scalar Kalman filter (A = H = 1) on signed fixed-point samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  apb       slave      psel/penable, pready   paddr, pwdata, prdata
//  s_axis    in         s_tvalid/s_tready      s_tdata: measurement
//  m_axis    out        m_tvalid/m_tready      m_tdata: estimate
//
// From acceptance to the output register an item runs on the single shared
// adder (Q16.16 by default), which does the restoring divide and both
// shift-add multiplies one bit a cycle.
// s_tready is high only while no item is in progress.
// Reset clears estimate and covariance; both noise registers reset to 1.0.
// A result waiting in the output register does not stop a new measurement
// from being taken; the next result then holds until the register frees.
// ----------------------------------------------------------------------------
module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int BUS_WIDTH   = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB    = (DATA_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_WIDTH  = ADDR_LSB + 1,
    localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [BUS_WIDTH-1:0]  pwdata,
    output logic [BUS_WIDTH-1:0]  prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_WIDTH-1:0] s_tdata,  // [DATA_WIDTH-1:0] measurement
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_WIDTH-1:0] m_tdata   // [DATA_WIDTH-1:0] estimate
);

    logic [DATA_WIDTH-1:0]  process_noise;
    logic [DATA_WIDTH-1:0]  measure_noise;
    logic                   slot_free;
    logic                   res_valid;
    logic [DATA_WIDTH-1:0]  estimate;
    logic                   m_tvalid_reg;
    logic [TDATA_WIDTH-1:0] m_tdata_reg;

    assign pready = 1'b1;

    skf_cfg #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .BUS_WIDTH  (BUS_WIDTH),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .process_noise (process_noise),
        .measure_noise (measure_noise)
    );

    skf_core #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .process_noise (process_noise),
        .measure_noise (measure_noise),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .measurement   (s_tdata[DATA_WIDTH-1:0]),
        .slot_free     (slot_free),
        .res_valid     (res_valid),
        .estimate      (estimate)
    );

    // Output register: free when empty or being drained this cycle
    assign slot_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_tdata_reg <= TDATA_WIDTH'(estimate);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
